[src/ccg_pkg.sv]
// ----------------------------------------------------------------------------
// ccg_pkg: shared types and constants of the charge gauge
// Widths, command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package ccg_pkg;

    localparam int SPP_DEFAULT   = 10;
    localparam int COUNT_W       = 4;
    localparam int DVD_W         = 70;
    localparam int DVS_W         = 22;
    localparam int DCNT_W        = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP  = 2'd1;

    localparam logic [31:0] GAIN_RESET   = 32'd2212495;
    localparam logic [15:0] CAP_RESET    = 16'd2000;
    localparam logic [DVS_W-1:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [31:0] PCT_SCALE    = 32'd10000;

    // ms per hour = 128 * 28125; ceil(2^46 / 28125) is exact for 31-bit operands
    localparam logic [31:0] HOUR_RECIP   = 32'd2501999793;
    localparam int          HD_DIGITS    = 5;

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_ACCEPT,
        STEP_MUL_SUM,
        STEP_DIVA,
        STEP_AVG_FIX,
        STEP_MUL_LO,
        STEP_MUL_HI,
        STEP_ACC_HI,
        STEP_DIVD,
        STEP_REM_UPD,
        STEP_PCT_ABS,
        STEP_MUL_PLO,
        STEP_MUL_PHI,
        STEP_ACC_PHI,
        STEP_DIVP,
        STEP_PCT_FIX
    } t_step;

    typedef struct packed {
        t_step step;
        logic  out_load;
        logic  out_close;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic div_busy;
    } t_sts;

endpackage

[src/ccg_div.sv]
// ----------------------------------------------------------------------------
// ccg_div: restoring unsigned divider
// One quotient bit per cycle over the full dividend width.
// ----------------------------------------------------------------------------
module ccg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ccg_pkg::DVD_W-1:0] i_dividend,
    input  logic [ccg_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [ccg_pkg::DVD_W-1:0] o_quotient
);
    import ccg_pkg::*;

    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_dvd;

endmodule

[src/ccg_dp.sv]
// ----------------------------------------------------------------------------
// ccg_dp: charge gauge datapath
// Sample accumulation, shared multiplier and divider, charge and percent.
// ----------------------------------------------------------------------------
module ccg_dp #(
    parameter int SAMPLES_PER_PERIOD = ccg_pkg::SPP_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ccg_pkg::t_cmd                  i_cmd,
    output ccg_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_we,
    input  logic [ccg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ccg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic signed [15:0]             i_cc_sample,
    input  logic [31:0]                    i_time_ms,
    output logic signed [15:0]             o_percent_centi,
    output logic signed [21:0]             o_avg_current_ma,
    output logic signed [23:0]             o_remaining_mah,
    output logic                           o_period_done
);
    import ccg_pkg::*;

    localparam logic [37:0] AVG_LIM_POS = 38'h1F_FFFF_FFFF;
    localparam logic [37:0] AVG_LIM_NEG = 38'h20_0000_0000;
    localparam logic [15:0] PCT_LIM_POS = 16'h7FFF;
    localparam logic [15:0] PCT_LIM_NEG = 16'h8000;

    logic [31:0]         r_gain;
    logic [15:0]         r_cap;
    logic signed [23:0]  r_sum;
    logic [COUNT_W-1:0]  r_count;
    logic [31:0]         r_start;
    logic [31:0]         r_elapsed;
    logic signed [47:0]  r_rem;
    logic signed [15:0]  r_pct;
    logic signed [21:0]  r_avg_ma;
    logic [37:0]         r_mag;
    logic                r_neg;
    logic [55:0]         r_prod;
    logic [DVD_W-1:0]    r_acc;
    logic [79:0]         r_hd_dvd;
    logic [21:0]         r_hd_rem;
    logic [48:0]         r_hd_quo;
    logic [61:0]         r_hd_prod;
    logic [3:0]          r_hd_cnt;

    logic [23:0]         sum_abs;
    logic [47:0]         rem_abs;
    logic [23:0]         mul_a;
    logic [31:0]         mul_b;
    logic                div_start;
    logic [DVD_W-1:0]    div_dvd;
    logic [DVS_W-1:0]    div_dvs;
    logic                div_busy;
    logic [DVD_W-1:0]    div_q;
    logic [37:0]         avg_lim;
    logic [37:0]         mag_c;
    logic [21:0]         mag_sh;
    logic signed [49:0]  rem_ext;
    logic signed [49:0]  dq;
    logic signed [49:0]  rem_new;
    logic [15:0]         pct_lim;
    logic [15:0]         pct_mag;
    logic signed [47:0]  rem_adj;
    logic signed [31:0]  rem_q;
    logic signed [23:0]  rem_int;
    logic [15:0]         cap_eff;
    logic signed [23:0]  cc_ext;
    logic [37:0]         hd_val;
    logic [15:0]         hd_digit;
    logic [37:0]         hd_rem;
    logic                hd_busy;

    assign sum_abs = r_sum[23] ? 24'(-r_sum) : 24'(r_sum);
    assign rem_abs = r_rem[47] ? 48'(-r_rem) : 48'(r_rem);
    assign cap_eff = (r_cap == '0) ? 16'd1 : r_cap;
    assign cc_ext  = 24'(i_cc_sample);

    always_comb begin
        case (i_cmd.step)
            STEP_MUL_SUM: begin mul_a = sum_abs;              mul_b = r_gain;    end
            STEP_MUL_LO:  begin mul_a = {5'b0, r_mag[18:0]};  mul_b = r_elapsed; end
            STEP_MUL_HI:  begin mul_a = {5'b0, r_mag[37:19]}; mul_b = r_elapsed; end
            STEP_MUL_PLO: begin mul_a = r_acc[23:0];          mul_b = PCT_SCALE; end
            STEP_MUL_PHI: begin mul_a = r_acc[47:24];         mul_b = PCT_SCALE; end
            default:      begin mul_a = '0;                   mul_b = '0;        end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        case (i_cmd.step)
            STEP_DIVA: begin
                div_start = 1'b1;
                div_dvd   = {14'b0, r_prod};
                div_dvs   = {{(DVS_W-COUNT_W){1'b0}}, r_count};
            end
            STEP_DIVP: begin
                div_start = 1'b1;
                div_dvd   = {16'b0, r_acc[DVD_W-1:16]};
                div_dvs   = {6'b0, cap_eff};
            end
            default: ;
        endcase
    end

    ccg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    // divide by one hour: base 2^16 long division, a reciprocal multiply then a remainder update per digit
    assign hd_val   = {r_hd_rem, r_hd_dvd[79:64]};
    assign hd_digit = r_hd_prod[61:46];
    assign hd_rem   = hd_val - 38'(hd_digit) * 38'(MS_PER_HOUR);
    assign hd_busy  = (r_hd_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_cnt <= '0;
        end else if (i_cmd.step == STEP_DIVD) begin
            r_hd_cnt <= 4'(2 * HD_DIGITS);
        end else if (r_hd_cnt != '0) begin
            r_hd_cnt <= r_hd_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step == STEP_DIVD) begin
            r_hd_dvd <= {10'b0, r_acc};
            r_hd_rem <= '0;
            r_hd_quo <= '0;
        end else if (r_hd_cnt != '0) begin
            if (!r_hd_cnt[0]) begin
                r_hd_prod <= 62'(hd_val[37:7]) * 62'(HOUR_RECIP);
            end else begin
                r_hd_rem <= hd_rem[21:0];
                r_hd_dvd <= {r_hd_dvd[63:0], 16'b0};
                r_hd_quo <= {r_hd_quo[32:0], hd_digit};
            end
        end
    end

    // average clamp on magnitude, asymmetric by sign
    assign avg_lim = r_neg ? AVG_LIM_NEG : AVG_LIM_POS;
    assign mag_c   = ((div_q[DVD_W-1:38] != '0) || (div_q[37:0] > avg_lim)) ? avg_lim
                                                                           : div_q[37:0];
    assign mag_sh  = mag_c[37:16];

    assign rem_ext = 50'(r_rem);
    assign dq      = {1'b0, r_hd_quo};
    assign rem_new = r_neg ? rem_ext + dq : rem_ext - dq;

    assign pct_lim = r_neg ? PCT_LIM_NEG : PCT_LIM_POS;
    assign pct_mag = ((div_q[DVD_W-1:16] != '0) || (div_q[15:0] > pct_lim)) ? pct_lim
                                                                           : div_q[15:0];

    // remaining charge in mAh, truncated toward zero
    assign rem_adj = r_rem + (r_rem[47] ? 48'sd65535 : 48'sd0);
    assign rem_q   = rem_adj[47:16];
    always_comb begin
        if (rem_q > 32'sd8388607) begin
            rem_int = 24'sd8388607;
        end else if (rem_q < -32'sd8388608) begin
            rem_int = -24'sd8388608;
        end else begin
            rem_int = rem_q[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_cap   <= CAP_RESET;
            r_sum   <= '0;
            r_count <= '0;
            r_start <= '0;
            r_rem   <= 48'(CAP_RESET) <<< 16;
            r_pct   <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_GAIN) begin
                r_gain <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_index == REG_CAP) begin
                r_cap <= i_cfg_wdata[15:0];
                r_rem <= 48'(i_cfg_wdata[15:0]) <<< 16;
            end
            case (i_cmd.step)
                STEP_ACCEPT: begin
                    if (r_count == '0) begin
                        r_start <= i_time_ms;
                    end
                    r_sum   <= r_sum + cc_ext;
                    r_count <= r_count + 1'b1;
                end
                STEP_REM_UPD: begin
                    if (rem_new[49:47] == 3'b000 || rem_new[49:47] == 3'b111) begin
                        r_rem <= rem_new[47:0];
                    end else begin
                        r_rem <= rem_new[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
                    end
                end
                STEP_PCT_FIX: begin
                    r_pct   <= r_neg ? 16'(-pct_mag) : 16'(pct_mag);
                    r_sum   <= '0;
                    r_count <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.step)
            STEP_ACCEPT: begin
                r_elapsed <= (r_count == '0) ? 32'd0 : i_time_ms - r_start;
            end
            STEP_MUL_SUM: begin
                r_prod <= 56'(mul_a) * 56'(mul_b);
                r_neg  <= r_sum[23];
            end
            STEP_AVG_FIX: begin
                r_mag    <= mag_c;
                r_avg_ma <= r_neg ? 22'(-mag_sh) : 22'(mag_sh);
            end
            STEP_MUL_LO: begin
                r_prod <= 56'(mul_a) * 56'(mul_b);
            end
            STEP_MUL_HI: begin
                r_prod <= 56'(mul_a) * 56'(mul_b);
                r_acc  <= DVD_W'(r_prod);
            end
            STEP_ACC_HI: begin
                r_acc <= r_acc + (DVD_W'(r_prod) << 19);
            end
            STEP_PCT_ABS: begin
                r_acc <= DVD_W'(rem_abs);
                r_neg <= r_rem[47];
            end
            STEP_MUL_PLO: begin
                r_prod <= 56'(mul_a) * 56'(mul_b);
            end
            STEP_MUL_PHI: begin
                r_prod <= 56'(mul_a) * 56'(mul_b);
                r_acc  <= DVD_W'(r_prod);
            end
            STEP_ACC_PHI: begin
                r_acc <= r_acc + (DVD_W'(r_prod) << 24);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_percent_centi  <= r_pct;
            o_avg_current_ma <= i_cmd.out_close ? r_avg_ma : 22'sd0;
            o_remaining_mah  <= rem_int;
            o_period_done    <= i_cmd.out_close;
        end
    end

    assign o_sts.close    = ({1'b0, r_count} + 1'b1) >= (COUNT_W+1)'(SAMPLES_PER_PERIOD);
    assign o_sts.div_busy = div_busy || hd_busy;

endmodule

[src/ccg_ctrl.sv]
// ----------------------------------------------------------------------------
// ccg_ctrl: charge gauge controller
// Request handshakes and the step sequence of a period close.
// ----------------------------------------------------------------------------
module ccg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  ccg_pkg::t_sts i_sts,
    output ccg_pkg::t_cmd o_cmd
);
    import ccg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_SUM,
        ST_DIVA_GO,
        ST_DIVA_WAIT,
        ST_AVG_FIX,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC_HI,
        ST_DIVD_GO,
        ST_DIVD_WAIT,
        ST_REM_UPD,
        ST_PCT_ABS,
        ST_MUL_PLO,
        ST_MUL_PHI,
        ST_ACC_PHI,
        ST_DIVP_GO,
        ST_DIVP_WAIT,
        ST_PCT_FIX,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !(r_state == ST_IDLE && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state         = r_state;
        o_cmd.step      = STEP_IDLE;
        o_cmd.out_load  = 1'b0;
        o_cmd.out_close = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.step = STEP_ACCEPT;
                    if (i_sts.close) begin
                        n_state = ST_MUL_SUM;
                    end else begin
                        o_cmd.out_load = 1'b1;
                    end
                end
            end
            ST_MUL_SUM:   begin o_cmd.step = STEP_MUL_SUM; n_state = ST_DIVA_GO; end
            ST_DIVA_GO:   begin o_cmd.step = STEP_DIVA;    n_state = ST_DIVA_WAIT; end
            ST_DIVA_WAIT: begin if (!i_sts.div_busy) n_state = ST_AVG_FIX; end
            ST_AVG_FIX:   begin o_cmd.step = STEP_AVG_FIX; n_state = ST_MUL_LO; end
            ST_MUL_LO:    begin o_cmd.step = STEP_MUL_LO;  n_state = ST_MUL_HI; end
            ST_MUL_HI:    begin o_cmd.step = STEP_MUL_HI;  n_state = ST_ACC_HI; end
            ST_ACC_HI:    begin o_cmd.step = STEP_ACC_HI;  n_state = ST_DIVD_GO; end
            ST_DIVD_GO:   begin o_cmd.step = STEP_DIVD;    n_state = ST_DIVD_WAIT; end
            ST_DIVD_WAIT: begin if (!i_sts.div_busy) n_state = ST_REM_UPD; end
            ST_REM_UPD:   begin o_cmd.step = STEP_REM_UPD; n_state = ST_PCT_ABS; end
            ST_PCT_ABS:   begin o_cmd.step = STEP_PCT_ABS; n_state = ST_MUL_PLO; end
            ST_MUL_PLO:   begin o_cmd.step = STEP_MUL_PLO; n_state = ST_MUL_PHI; end
            ST_MUL_PHI:   begin o_cmd.step = STEP_MUL_PHI; n_state = ST_ACC_PHI; end
            ST_ACC_PHI:   begin o_cmd.step = STEP_ACC_PHI; n_state = ST_DIVP_GO; end
            ST_DIVP_GO:   begin o_cmd.step = STEP_DIVP;    n_state = ST_DIVP_WAIT; end
            ST_DIVP_WAIT: begin if (!i_sts.div_busy) n_state = ST_PCT_FIX; end
            ST_PCT_FIX:   begin o_cmd.step = STEP_PCT_FIX; n_state = ST_OUT; end
            ST_OUT: begin
                if (out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_close = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.out_load)
        else $error("result register overwritten while stalled");

    a_close_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_sts.close) |=> (r_state == ST_MUL_SUM))
        else $error("closing request did not start the period sequence");

    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVD_WAIT && i_sts.div_busy) |=> (r_state == ST_DIVD_WAIT))
        else $error("left divide wait while divider busy");

endmodule

[src/coulomb_counter_charge_gauge_unit.sv]
// ----------------------------------------------------------------------------
// coulomb_counter_charge_gauge_unit: coulomb-counting state of charge
// A request that does not close a period has its result registered at the
// accepting edge. A closing request runs through two 70-bit divisions in the
// shared restoring divider and a divide by one hour; no new request is taken
// meanwhile. Synchronous active-low reset restores register defaults.
// ----------------------------------------------------------------------------
module coulomb_counter_charge_gauge_unit #(
    parameter int SAMPLES_PER_PERIOD = ccg_pkg::SPP_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [15:0]             i_cc_sample,
    input  logic [31:0]                    i_time_ms,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [15:0]             o_percent_centi,
    output logic signed [21:0]             o_avg_current_ma,
    output logic signed [23:0]             o_remaining_mah,
    output logic                           o_period_done,
    input  logic                           i_cfg_we,
    input  logic [ccg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ccg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ccg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ccg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ccg_dp #(
        .SAMPLES_PER_PERIOD (SAMPLES_PER_PERIOD)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cc_sample      (i_cc_sample),
        .i_time_ms        (i_time_ms),
        .o_percent_centi  (o_percent_centi),
        .o_avg_current_ma (o_avg_current_ma),
        .o_remaining_mah  (o_remaining_mah),
        .o_period_done    (o_period_done)
    );

endmodule

[bench/coulomb_counter_charge_gauge_unit_tb.sv]
// ----------------------------------------------------------------------------
// coulomb_counter_charge_gauge_unit_tb: self-checking bench of the charge gauge
// A table of directed requests is driven first. Random sample streams follow,
// under several gain and capacity settings. Each request is scored against
// a bit-exact gauge predictor in the bench, or its table row if typed. Random
// stalls on both sides and one long output hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module coulomb_counter_charge_gauge_unit_tb;
    import ccg_pkg::*;

    localparam int  SPP        = SPP_DEFAULT;
    localparam int  IDLE_LIMIT = 5000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [15:0] pct;
        logic signed [21:0] avg;
        logic signed [23:0] rem;
        logic               done;
    } t_gauge_res;

    typedef struct {
        logic signed [15:0] cc;
        logic [31:0]        tm;
        bit                 typed;
        logic signed [15:0] pct;
        logic signed [23:0] rem;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic signed [15:0]     i_cc_sample;
    logic [31:0]            i_time_ms;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic signed [15:0]     o_percent_centi;
    logic signed [21:0]     o_avg_current_ma;
    logic signed [23:0]     o_remaining_mah;
    logic                   o_period_done;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    coulomb_counter_charge_gauge_unit dut (.*);

    // gauge state mirrored by the predictor
    logic [31:0]  gain_q16;
    logic [15:0]  cap_mah;
    int           run_sum;
    int           run_count;
    logic [31:0]  start_ms;
    longint       charge_q16;
    longint       held_pct;

    t_gauge_res   expected_q[$];
    int           errors = 0;
    int           results_seen = 0;
    int           periods_seen = 0;
    int           idle_cycles = 0;
    bit           idle_on = 1'b1;
    bit           long_hold = 1'b0;
    logic [31:0]  now_ms = 32'd0;

    t_dir_row dir_rows [20] = '{
        '{16'sh7FFF, 32'd0,          1'b1, 16'sd0, 24'sd2000},
        '{16'sh8000, 32'd100,        1'b1, 16'sd0, 24'sd2000},
        '{16'sh0000, 32'd200,        1'b1, 16'sd0, 24'sd2000},
        '{16'sh0001, 32'd300,        1'b1, 16'sd0, 24'sd2000},
        '{16'shFFFF, 32'd400,        1'b1, 16'sd0, 24'sd2000},
        '{16'sh5555, 32'd500,        1'b1, 16'sd0, 24'sd2000},
        '{16'shAAAA, 32'd600,        1'b1, 16'sd0, 24'sd2000},
        '{16'sh7FFF, 32'd700,        1'b1, 16'sd0, 24'sd2000},
        '{16'sh7FFF, 32'd800,        1'b1, 16'sd0, 24'sd2000},
        '{16'sh7FFF, 32'hFFFF_FFFF,  1'b0, 16'sd0, 24'sd0},
        '{16'sh8000, 32'hFFFF_F000,  1'b0, 16'sd0, 24'sd0},
        '{16'sh8000, 32'hFFFF_F800,  1'b0, 16'sd0, 24'sd0},
        '{16'sh8000, 32'hFFFF_FC00,  1'b0, 16'sd0, 24'sd0},
        '{16'sh8000, 32'hFFFF_FF00,  1'b0, 16'sd0, 24'sd0},
        '{16'sh8000, 32'hFFFF_FFFF,  1'b0, 16'sd0, 24'sd0},
        '{16'sh8000, 32'h0000_0000,  1'b0, 16'sd0, 24'sd0},
        '{16'sh8000, 32'h0000_0010,  1'b0, 16'sd0, 24'sd0},
        '{16'sh8000, 32'h0000_0040,  1'b0, 16'sd0, 24'sd0},
        '{16'sh8000, 32'h0000_0080,  1'b0, 16'sd0, 24'sd0},
        '{16'sh8000, 32'h0036_EE80,  1'b0, 16'sd0, 24'sd0}
    };

    function automatic longint clamp_l(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_gauge_res gauge_step(logic signed [15:0] cc, logic [31:0] now);
        t_gauge_res r;
        longint     prod, avg, hours, rest, delta, elapsed, cap;
        if (run_count == 0) start_ms = now;
        run_sum   += int'(cc);
        run_count  = (run_count + 1) & 15;
        r.avg  = '0;
        r.done = 1'b0;
        if (run_count >= SPP) begin
            elapsed = longint'({32'd0, now - start_ms});
            prod  = longint'(run_sum) * longint'({32'd0, gain_q16});
            avg   = clamp_l(prod / longint'(run_count), -(64'sd1 <<< 37),
                            (64'sd1 <<< 37) - 1);
            hours = elapsed / 3600000;
            rest  = elapsed % 3600000;
            delta = avg * hours + (avg * rest) / 3600000;
            r.avg = 22'(avg / 65536);
            charge_q16 = clamp_l(charge_q16 - delta, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
            cap = (cap_mah == 16'd0) ? 64'sd1 : longint'({48'd0, cap_mah});
            held_pct = clamp_l((charge_q16 * 10000) / (cap * 65536), -32768, 32767);
            run_sum   = 0;
            run_count = 0;
            r.done    = 1'b1;
        end
        r.pct = 16'(held_pct);
        r.rem = 24'(clamp_l(charge_q16 / 65536, -8388608, 8388607));
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stall bursts plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                long_hold = 1'b0;
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_gauge_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result pct=%0d avg=%0d rem=%0d done=%0b", $time,
                         o_percent_centi, o_avg_current_ma, o_remaining_mah, o_period_done);
            end else begin
                e = expected_q.pop_front();
                if (e.done) periods_seen++;
                if (o_percent_centi !== e.pct || o_avg_current_ma !== e.avg ||
                    o_remaining_mah !== e.rem || o_period_done !== e.done) begin
                    errors++;
                    $display("%0t: mismatch expected pct=%0d avg=%0d rem=%0d done=%0b",
                             $time, e.pct, e.avg, e.rem, e.done);
                    $display("%0t:          actual   pct=%0d avg=%0d rem=%0d done=%0b",
                             $time, o_percent_centi, o_avg_current_ma, o_remaining_mah,
                             o_period_done);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_GAIN) begin
            gain_q16 = val;
        end else if (idx == REG_CAP) begin
            cap_mah    = val[15:0];
            charge_q16 = longint'({48'd0, val[15:0]}) * 65536;
        end
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic send_request(logic signed [15:0] cc, logic [31:0] tm, bit typed,
                                t_gauge_res typed_res);
        t_gauge_res r;
        if (idle_on && $urandom_range(0, 6) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cc_sample <= cc;
        i_time_ms   <= tm;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = gauge_step(cc, tm);
        expected_q.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic random_stream(int n);
        t_gauge_res none;
        logic signed [15:0] cc;
        bit frozen;
        none = '{default: '0};
        frozen = 1'b0;
        for (int k = 0; k < n; k++) begin
            if (run_count == 0) frozen = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 3))
                0: cc = 16'($urandom);
                1: cc = 16'($signed($urandom_range(0, 200)) - 100);
                2: cc = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                default: cc = 16'($signed($urandom_range(0, 4000)) - 2000);
            endcase
            if (!frozen) begin
                case ($urandom_range(0, 19))
                    0: now_ms = $urandom;
                    1: now_ms = now_ms + $urandom_range(0, 32'd400_000_000);
                    default: now_ms = now_ms + $urandom_range(1, 2000);
                endcase
            end
            send_request(cc, now_ms, 1'b0, none);
        end
    endtask

    initial begin
        t_gauge_res tr;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_cc_sample = '0;
        i_time_ms   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_GAIN;
        i_cfg_wdata = '0;
        gain_q16    = GAIN_RESET;
        cap_mah     = CAP_RESET;
        run_sum     = 0;
        run_count   = 0;
        start_ms    = '0;
        charge_q16  = longint'({48'd0, CAP_RESET}) * 65536;
        held_pct    = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            tr = '{dir_rows[k].pct, 22'sd0, dir_rows[k].rem, 1'b0};
            send_request(dir_rows[k].cc, dir_rows[k].tm, dir_rows[k].typed, tr);
        end

        long_hold = 1'b1;
        random_stream(400);

        i_in_valid <= 1'b0;
        wait_drained();
        write_reg(REG_GAIN, 32'd0);
        write_reg(REG_CAP, 32'd1);
        random_stream(200);

        i_in_valid <= 1'b0;
        wait_drained();
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_CAP, 32'd65535);
        random_stream(300);

        i_in_valid <= 1'b0;
        wait_drained();
        write_reg(REG_CAP, 32'd0);
        write_reg(REG_GAIN, $urandom);
        random_stream(200);

        i_in_valid <= 1'b0;
        wait_drained();
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_GAIN, $urandom_range(0, 32'h0040_0000));
        write_reg(REG_CAP, $urandom_range(1, 65535));
        random_stream(300);

        i_in_valid <= 1'b0;
        wait_drained();
        write_reg(REG_GAIN, GAIN_RESET);
        write_reg(REG_CAP, 32'd1);
        idle_on = 1'b0;
        random_stream(300);
        i_in_valid <= 1'b0;

        for (int w = 0; w < IDLE_LIMIT && expected_q.size() != 0; w++) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("Checked %0d results, %0d of them closing a period,", results_seen,
                 periods_seen);
        $display("over six gain/capacity settings with stalls on both sides.");
        if (errors == 0 && expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
